FILE: rtl/wtpm_pkg.sv
package wtpm_pkg;

   // Field widths.
   localparam int MS_BITS       = 16;
   localparam int DRIVE_BITS    = 2;
   localparam int FLOW_BITS     = 16;
   localparam int RATE_BITS     = 16;
   localparam int PROD_BITS     = MS_BITS + RATE_BITS;
   localparam int TEMP_BITS     = 17;
   localparam int VOL_BITS      = 40;
   localparam int SUM_BITS      = VOL_BITS + 2;
   localparam int LFSR_BITS     = 16;
   localparam int SENSOR_BITS   = 3;

   // Port widths.
   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 48;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 40;

   // Register map.
   localparam logic [CSR_IDX_BITS-1:0] CSR_CAPACITY      = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PUMP_ONE_RATE = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_PUMP_TWO_RATE = 2'd2;

   // Reset values and thresholds.
   localparam logic [VOL_BITS-1:0]  CAP_RESET  = 40'd1000000000;
   localparam logic [VOL_BITS-1:0]  VOL_RESET  = CAP_RESET >> 1;
   localparam logic [RATE_BITS-1:0] RATE_RESET = 16'd1000;
   localparam logic [TEMP_BITS-1:0] TEMP_MAX   = 17'd100000;
   localparam logic [TEMP_BITS-1:0] TEMP_HOT   = 17'd85000;
   localparam logic [LFSR_BITS-1:0] LFSR_SEED  = 16'hACE1;

   // Drive codes.
   localparam logic [DRIVE_BITS-1:0] DRIVE_OFF    = 2'b00;
   localparam logic [DRIVE_BITS-1:0] DRIVE_DOUBLE = 2'b11;

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic                     valid;
      logic [CSR_IDX_BITS-1:0]  index;
      logic [CSR_DATA_BITS-1:0] data;
   } csr_write_type;

   typedef struct packed {
      logic [MS_BITS-1:0]    elapsed_ms;
      logic [DRIVE_BITS-1:0] pump_one_drive;
      logic [DRIVE_BITS-1:0] pump_two_drive;
      logic [PROD_BITS-1:0]  pump_one_flow;
      logic [PROD_BITS-1:0]  pump_two_flow;
      logic [PROD_BITS-1:0]  removed;
      logic                  make_fault;
      logic                  clear_fault;
   } cmd_type;

   typedef struct packed {
      logic                low_sensor;
      logic                mid_sensor;
      logic                high_sensor;
      logic                pump_one_hot;
      logic                pump_two_hot;
      logic [VOL_BITS-1:0] tank_volume_ul;
      logic                fault_active;
   } result_type;

   typedef enum logic [1:0] {
      BK_TAKE,
      BK_SETTLE,
      BK_EMIT
   } back_state_type;

   // Frozen sensor pattern; bit 0 is low, bit 1 is mid, bit 2 is high.
   function automatic logic [SENSOR_BITS-1:0] fault_pattern(input logic [1:0] sel);
      logic [SENSOR_BITS-1:0] pat;
      unique case (sel)
         2'd0:    pat = 3'b010;
         2'd1:    pat = 3'b100;
         2'd2:    pat = 3'b101;
         default: pat = 3'b110;
      endcase
      return pat;
   endfunction

   // Fibonacci step with taps at bits 0, 2, 3 and 5, fed back into bit 15.
   function automatic logic [LFSR_BITS-1:0] lfsr_next(input logic [LFSR_BITS-1:0] s);
      logic fb;
      fb = s[0] ^ s[2] ^ s[3] ^ s[5];
      return {fb, s[LFSR_BITS-1:1]};
   endfunction

   // Temperature step, clamped to 0..TEMP_MAX.
   function automatic logic [TEMP_BITS-1:0] heat(input logic [TEMP_BITS-1:0] temp,
                                                 input logic running,
                                                 input logic [MS_BITS-1:0] ms);
      logic [MS_BITS+1:0] rise;
      logic [MS_BITS+2:0] fall;
      logic [MS_BITS+2:0] warm;
      logic [TEMP_BITS-1:0] res;
      rise = {2'b00, ms} + {1'b0, ms, 1'b0};
      fall = {rise, 1'b0};
      warm = {2'b00, temp} + {1'b0, rise};
      if (running) begin
         res = (warm > {2'b00, TEMP_MAX}) ? TEMP_MAX : warm[TEMP_BITS-1:0];
      end else begin
         res = (fall >= {2'b00, temp}) ? '0 : temp - fall[TEMP_BITS-1:0];
      end
      return res;
   endfunction

endpackage

FILE: rtl/wtpm_front.sv
module wtpm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  wtpm_pkg::csr_write_type           csr,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [wtpm_pkg::MS_BITS-1:0]      elapsed_ms,
   input  logic [wtpm_pkg::DRIVE_BITS-1:0]   pump_one_drive,
   input  logic [wtpm_pkg::DRIVE_BITS-1:0]   pump_two_drive,
   input  logic                              request_valid,
   input  logic [wtpm_pkg::FLOW_BITS-1:0]    demand_flow,
   input  logic                              make_fault,
   input  logic                              clear_fault,
   output logic                              cmd_valid,
   input  logic                              cmd_ready,
   output wtpm_pkg::cmd_type                 cmd
);
   import wtpm_pkg::*;

   logic [RATE_BITS-1:0] rate_one_ff, rate_one_in;
   logic [RATE_BITS-1:0] rate_two_ff, rate_two_in;
   logic [FLOW_BITS-1:0] held_demand_ff, held_demand_in;
   logic                 held_make_ff, held_make_in;
   logic                 held_clear_ff, held_clear_in;

   logic                 accept;
   logic [FLOW_BITS-1:0] demand_now;

   assign req_ready = cmd_ready;
   assign cmd_valid = req_valid;
   assign accept    = req_valid && cmd_ready;

   // A beat that carries a request replaces the held demand and fault flags,
   // and already uses the new values for its own tick.
   assign demand_now = request_valid ? demand_flow : held_demand_ff;

   always_comb begin
      cmd.elapsed_ms     = elapsed_ms;
      cmd.pump_one_drive = pump_one_drive;
      cmd.pump_two_drive = pump_two_drive;
      cmd.pump_one_flow  = PROD_BITS'(rate_one_ff) * PROD_BITS'(elapsed_ms);
      cmd.pump_two_flow  = PROD_BITS'(rate_two_ff) * PROD_BITS'(elapsed_ms);
      cmd.removed        = PROD_BITS'(demand_now) * PROD_BITS'(elapsed_ms);
      cmd.make_fault     = request_valid ? make_fault  : held_make_ff;
      cmd.clear_fault    = request_valid ? clear_fault : held_clear_ff;
   end

   always_comb begin
      rate_one_in    = rate_one_ff;
      rate_two_in    = rate_two_ff;
      held_demand_in = held_demand_ff;
      held_make_in   = held_make_ff;
      held_clear_in  = held_clear_ff;
      if (csr.valid && (csr.index == CSR_PUMP_ONE_RATE)) begin
         rate_one_in = csr.data[RATE_BITS-1:0];
      end
      if (csr.valid && (csr.index == CSR_PUMP_TWO_RATE)) begin
         rate_two_in = csr.data[RATE_BITS-1:0];
      end
      if (accept && request_valid) begin
         held_demand_in = demand_flow;
         held_make_in   = make_fault;
         held_clear_in  = clear_fault;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_one_ff    <= RATE_RESET;
         rate_two_ff    <= RATE_RESET;
         held_demand_ff <= '0;
         held_make_ff   <= 1'b0;
         held_clear_ff  <= 1'b0;
      end else begin
         rate_one_ff    <= rate_one_in;
         rate_two_ff    <= rate_two_in;
         held_demand_ff <= held_demand_in;
         held_make_ff   <= held_make_in;
         held_clear_ff  <= held_clear_in;
      end
   end

endmodule

FILE: rtl/wtpm_queue.sv
module wtpm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  wtpm_pkg::cmd_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output wtpm_pkg::cmd_type pop_data
);
   import wtpm_pkg::*;

   cmd_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   function automatic logic [QPTR_BITS-1:0] bump(input logic [QPTR_BITS-1:0] p);
      return (p == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: rtl/wtpm_back.sv
module wtpm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  wtpm_pkg::csr_write_type csr,
   input  logic                    cmd_valid,
   output logic                    cmd_ready,
   input  wtpm_pkg::cmd_type       cmd,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output wtpm_pkg::result_type    rsp
);
   import wtpm_pkg::*;

   back_state_type         state_ff, state_in;
   logic [VOL_BITS-1:0]    cap_ff, cap_in;
   logic [VOL_BITS-1:0]    vol_ff, vol_in;
   logic [TEMP_BITS-1:0]   temp_one_ff, temp_one_in;
   logic [TEMP_BITS-1:0]   temp_two_ff, temp_two_in;
   logic                   fault_ff, fault_in;
   logic [SENSOR_BITS-1:0] frozen_ff, frozen_in;
   logic [LFSR_BITS-1:0]   lfsr_ff, lfsr_in;
   logic [SUM_BITS-1:0]    sum_ff, sum_in;
   logic [PROD_BITS-1:0]   removed_ff, removed_in;
   logic                   hot_one_ff, hot_one_in;
   logic                   hot_two_ff, hot_two_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;

   logic                   take;
   logic                   settle;
   logic                   slot_free;
   logic                   emit;
   logic [PROD_BITS:0]     inflow_one;
   logic [PROD_BITS:0]     inflow_two;
   logic [SUM_BITS-1:0]    removed_ext;
   logic [SUM_BITS-1:0]    drained;
   logic [VOL_BITS+2:0]    five_vol;
   logic                   fault_step;
   logic [LFSR_BITS-1:0]   lfsr_step;

   // Water added by one pump; a pump at the top of its range adds nothing.
   function automatic logic [PROD_BITS:0] inflow(input logic [DRIVE_BITS-1:0] drive,
                                                  input logic [TEMP_BITS-1:0] temp,
                                                  input logic [PROD_BITS-1:0] flow);
      logic [PROD_BITS:0] q;
      if ((drive == DRIVE_OFF) || (temp >= TEMP_MAX)) begin
         q = '0;
      end else if (drive == DRIVE_DOUBLE) begin
         q = {flow, 1'b0};
      end else begin
         q = {1'b0, flow};
      end
      return q;
   endfunction

   // Sequencer: next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_TAKE:   if (cmd_valid) state_in = BK_SETTLE;
         BK_SETTLE: state_in = BK_EMIT;
         BK_EMIT:   if (slot_free) state_in = BK_TAKE;
         default:   state_in = BK_TAKE;
      endcase
   end

   // Sequencer: strobes.
   assign slot_free = !rsp_valid_ff || rsp_ready;
   always_comb begin
      take   = (state_ff == BK_TAKE) && cmd_valid;
      settle = (state_ff == BK_SETTLE);
      emit   = (state_ff == BK_EMIT) && slot_free;
   end

   assign cmd_ready = (state_ff == BK_TAKE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Take: gross volume, temperatures and fault latch, all from the state
   // left by the previous tick.
   assign inflow_one = inflow(cmd.pump_one_drive, temp_one_ff, cmd.pump_one_flow);
   assign inflow_two = inflow(cmd.pump_two_drive, temp_two_ff, cmd.pump_two_flow);
   assign lfsr_step  = lfsr_next(lfsr_ff);

   always_comb begin
      fault_step = fault_ff;
      if (cmd.clear_fault && fault_step) begin
         fault_step = 1'b0;
      end
   end

   // Settle: drain, then clamp to 0..capacity.
   assign removed_ext = SUM_BITS'(removed_ff);
   assign drained     = (removed_ext >= sum_ff) ? '0 : sum_ff - removed_ext;

   // Emit: level sensors against fixed fractions of the capacity.
   assign five_vol = {1'b0, vol_ff, 2'b00} + {3'b000, vol_ff};

   always_comb begin
      cap_in       = cap_ff;
      vol_in       = vol_ff;
      temp_one_in  = temp_one_ff;
      temp_two_in  = temp_two_ff;
      fault_in     = fault_ff;
      frozen_in    = frozen_ff;
      lfsr_in      = lfsr_ff;
      sum_in       = sum_ff;
      removed_in   = removed_ff;
      hot_one_in   = hot_one_ff;
      hot_two_in   = hot_two_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (take) begin
         sum_in      = {2'b00, vol_ff} + SUM_BITS'(inflow_one) + SUM_BITS'(inflow_two);
         removed_in  = cmd.removed;
         hot_one_in  = (temp_one_ff >= TEMP_HOT);
         hot_two_in  = (temp_two_ff >= TEMP_HOT);
         temp_one_in = heat(temp_one_ff, cmd.pump_one_drive != DRIVE_OFF, cmd.elapsed_ms);
         temp_two_in = heat(temp_two_ff, cmd.pump_two_drive != DRIVE_OFF, cmd.elapsed_ms);
         fault_in    = fault_step;
         if (cmd.make_fault && !fault_step) begin
            fault_in  = 1'b1;
            lfsr_in   = lfsr_step;
            frozen_in = fault_pattern(lfsr_step[1:0]);
         end
      end

      if (settle) begin
         vol_in = (drained > {2'b00, cap_ff}) ? cap_ff : drained[VOL_BITS-1:0];
      end

      // Capacity write refills tank to half; send only when idle (unenforced).
      if (csr.valid && (csr.index == CSR_CAPACITY)) begin
         cap_in = csr.data[VOL_BITS-1:0];
         vol_in = {1'b0, csr.data[VOL_BITS-1:1]};
      end

      if (emit) begin
         rsp_valid_in          = 1'b1;
         rsp_in.pump_one_hot   = hot_one_ff;
         rsp_in.pump_two_hot   = hot_two_ff;
         rsp_in.tank_volume_ul = vol_ff;
         rsp_in.fault_active   = fault_ff;
         if (fault_ff) begin
            rsp_in.low_sensor  = frozen_ff[0];
            rsp_in.mid_sensor  = frozen_ff[1];
            rsp_in.high_sensor = frozen_ff[2];
         end else begin
            rsp_in.low_sensor  = (five_vol >= {3'b000, cap_ff});
            rsp_in.mid_sensor  = ({vol_ff, 1'b0} >= {1'b0, cap_ff});
            rsp_in.high_sensor = (five_vol >= {1'b0, cap_ff, 2'b00});
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff     <= sum_in;
      removed_ff <= removed_in;
      hot_one_ff <= hot_one_in;
      hot_two_ff <= hot_two_in;
      rsp_ff     <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_TAKE;
         cap_ff       <= CAP_RESET;
         vol_ff       <= VOL_RESET;
         temp_one_ff  <= '0;
         temp_two_ff  <= '0;
         fault_ff     <= 1'b0;
         frozen_ff    <= '0;
         lfsr_ff      <= LFSR_SEED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         vol_ff       <= vol_in;
         temp_one_ff  <= temp_one_in;
         temp_two_ff  <= temp_two_in;
         fault_ff     <= fault_in;
         frozen_ff    <= frozen_in;
         lfsr_ff      <= lfsr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_vol_within_cap: assert property (@(posedge clock) disable iff (reset)
      vol_ff <= cap_ff)
      else $error("tank volume exceeds capacity");

   a_temp_within_range: assert property (@(posedge clock) disable iff (reset)
      (temp_one_ff <= TEMP_MAX) && (temp_two_ff <= TEMP_MAX))
      else $error("pump temperature out of range");

   a_take_then_settle: assert property (@(posedge clock) disable iff (reset)
      (cmd_valid && cmd_ready) |=> (state_ff == BK_SETTLE))
      else $error("taken command did not move to settle");

   a_settle_then_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_SETTLE) |=> (state_ff == BK_EMIT))
      else $error("settle did not move to emit");

   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset)
      lfsr_ff != '0)
      else $error("pattern LFSR locked at zero");
`endif

endmodule

FILE: rtl/water_tank_plant_model_unit.sv
// Water tank plant model: one beat on the req channel is one simulation tick.
// req_tdata carries the elapsed time, both pump drives, the demand flow and the
// fault flags; req_tuser marks a beat whose demand and fault fields replace the
// held ones. Every tick returns exactly one rsp beat with the three level
// sensors, both pump hot flags, the new tank volume and the fault status.
// The csr channel writes the capacity (which refills the tank to half) and the
// two pump rates; it is always ready and should be used only while idle.
// A tick's command passes through the command queue and then the three-step
// volume sequencer in the back end (sum, drain and clamp, sense), whose result
// shows on rsp_tvalid; it takes no new command until that result is registered.
// A two-entry command queue sits between the front end, which does the three
// flow multiplies, and the back end, so req keeps being taken while a result
// waits; once the queue is full req_tready drops. When rsp_tready is low the
// result register holds its beat and the back end waits in its emit step.
// Synchronous reset returns capacity to 1e9 ul, volume to half, rates to
// 1000 ml/s, temperatures, held request and fault latch to zero, and empties
// the queue and the result register.
module water_tank_plant_model_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // elapsed_ms, pump_one_drive, pump_two_drive, demand_flow, make_fault,
   // clear_fault, zero fill
   input  logic [wtpm_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // request_valid
   input  logic                                 req_tuser,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // low_sensor, mid_sensor, high_sensor, pump_one_hot, pump_two_hot,
   // tank_volume_ul, fault_active, zero fill
   output logic [wtpm_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [wtpm_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [wtpm_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import wtpm_pkg::*;

   csr_write_type csr;
   cmd_type       front_cmd;
   cmd_type       queue_cmd;
   logic          front_valid;
   logic          front_ready;
   logic          queue_valid;
   logic          queue_ready;
   result_type    result;

   // Register writes complete in the cycle they are offered.
   assign csr_ready = 1'b1;
   always_comb begin
      csr.valid = csr_valid && csr_ready;
      csr.index = csr_index;
      csr.data  = csr_data;
   end

   // Unpack the request beat and hand it to the front end.
   wtpm_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr            (csr),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .elapsed_ms     (req_tdata[15:0]),
      .pump_one_drive (req_tdata[17:16]),
      .pump_two_drive (req_tdata[19:18]),
      .request_valid  (req_tuser),
      .demand_flow    (req_tdata[35:20]),
      .make_fault     (req_tdata[36]),
      .clear_fault    (req_tdata[37]),
      .cmd_valid      (front_valid),
      .cmd_ready      (front_ready),
      .cmd            (front_cmd)
   );

   wtpm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_data   (queue_cmd)
   );

   wtpm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (result)
   );

   // Pack the result beat, first field in the lowest bit.
   assign rsp_tdata = {2'b00,
                       result.fault_active,
                       result.tank_volume_ul,
                       result.pump_two_hot,
                       result.pump_one_hot,
                       result.high_sensor,
                       result.mid_sensor,
                       result.low_sensor};

endmodule
